@@ rtl/core/fpfa_pkg.sv @@
// Shared constants for the fixed partition fit allocator.
// Holds register indexes, function and policy codes and fixed field widths.
// No dependencies.
package fpfa_pkg;

  // Fixed widths of the ports
  localparam int unsigned FUNC_W      = 1;
  localparam int unsigned ENTRY_W     = 5;
  localparam int unsigned REQ_SIZE_W  = 16;
  localparam int unsigned COUNT_W     = 6;
  localparam int unsigned POLICY_W    = 2;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 6;

  typedef logic [POLICY_W-1:0] policy_t;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POLICY = 1'd1;

  // Function codes of an input transaction
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

  // Fit policies
  localparam policy_t POLICY_FIRST  = 2'd0;
  localparam policy_t POLICY_BEST   = 2'd1;
  localparam policy_t POLICY_WORST  = 2'd2;
  localparam policy_t POLICY_REFUSE = 2'd3;

endpackage

@@ rtl/core/fpfa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the partition size table. No dependencies.
module fpfa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/fixed_partition_fit_allocator_unit.sv @@
// Fixed partition allocator with first, best and worst fit.
// Depends on fpfa_pkg and fpfa_ram.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o): func_i selects a load, which
//   writes one partition size and frees that partition, or an allocation
//   request for size_value_i.
// - Output channel (out_valid_o / out_stall_i): one transaction per request
//   with granted_o, granted_index_o and the echoed asked_size_o. Loads give
//   no output.
// - Configuration: cfg_we_i writes partition_count (index 0) or fit_policy
//   (index 1) from cfg_wdata_i; write only while the block is idle.
// Timing:
// - A load leaves the block idle; the next transaction may follow at once.
// - A request scans the size RAM one entry per cycle (one registered read
//   port); first fit stops at its first hit. With no partitions or the
//   refuse-all policy the scan is skipped and the request is refused.
// - A new transaction is accepted while a finished result waits in the
//   output register. If that register is still full when the next scan
//   ends, the block holds the result and stalls its input.
// Reset clears the used marks, the configuration registers and the control;
// the size table is undefined until loaded.
module fixed_partition_fit_allocator_unit #(
  parameter int unsigned MAX_PARTITIONS = 32,
  parameter int unsigned SIZE_BITS      = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write port
  input  logic                                  cfg_we_i,
  input  logic [fpfa_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [fpfa_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  // Input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [fpfa_pkg::FUNC_W-1:0]           func_i,
  input  logic [fpfa_pkg::ENTRY_W-1:0]          entry_index_i,
  input  logic [fpfa_pkg::REQ_SIZE_W-1:0]       size_value_i,
  // Output channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  granted_o,
  output logic [fpfa_pkg::ENTRY_W-1:0]          granted_index_o,
  output logic [fpfa_pkg::REQ_SIZE_W-1:0]       asked_size_o
);

  localparam int unsigned IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PARTITIONS + 1);
  localparam int unsigned CMP_W = (SIZE_BITS > fpfa_pkg::REQ_SIZE_W) ?
                                  SIZE_BITS : fpfa_pkg::REQ_SIZE_W;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Configuration registers
  logic [fpfa_pkg::COUNT_W-1:0] cfg_count_q;
  fpfa_pkg::policy_t            cfg_policy_q;

  // Control and scan state
  logic [1:0]                    state_q, state_d;
  logic [MAX_PARTITIONS-1:0]     used_q, used_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [CNT_W-1:0]              iss_q, iss_d;
  logic                          chk_valid_q, chk_valid_d;
  logic                          chk_last_q, chk_last_d;
  logic [IDX_W-1:0]              chk_idx_q, chk_idx_d;
  logic                          found_q, found_d;
  logic [IDX_W-1:0]              pick_q, pick_d;
  logic [SIZE_BITS-1:0]          best_q, best_d;
  logic [fpfa_pkg::REQ_SIZE_W-1:0] req_q, req_d;
  fpfa_pkg::policy_t             policy_q, policy_d;

  // Output register
  logic                          out_valid_q, out_valid_d;
  logic                          granted_q, granted_d;
  logic [fpfa_pkg::ENTRY_W-1:0]  gidx_q, gidx_d;
  logic [fpfa_pkg::REQ_SIZE_W-1:0] asked_q, asked_d;

  // Derived signals
  logic                          in_fire;
  logic                          out_free;
  logic                          load_ok;
  logic [31:0]                   ent_wide;
  logic [IDX_W-1:0]              ent_idx;
  logic [CMP_W-1:0]              wdata_wide;
  logic [CNT_W-1:0]              eff_count;
  logic                          issue;
  logic [SIZE_BITS-1:0]          rd_size;
  logic                          fits;
  logic                          cand;
  logic                          take;
  logic                          scan_end;
  logic [31:0]                   pick_wide;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !(out_valid_q && out_stall_i);

  // Load address check and write data
  assign ent_wide   = 32'(entry_index_i);
  assign load_ok    = (ent_wide < MAX_PARTITIONS);
  assign ent_idx    = ent_wide[IDX_W-1:0];
  assign wdata_wide = CMP_W'(size_value_i);

  // Partition count saturates at the table depth
  assign eff_count = (32'(cfg_count_q) > MAX_PARTITIONS) ?
                     CNT_W'(MAX_PARTITIONS) : CNT_W'(cfg_count_q);

  // Size table
  fpfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_PARTITIONS)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && (func_i == fpfa_pkg::FUNC_LOAD) && load_ok),
    .waddr_i (ent_idx),
    .wdata_i (wdata_wide[SIZE_BITS-1:0]),
    .raddr_i (iss_q[IDX_W-1:0]),
    .rdata_o (rd_size)
  );

  // Compare stage on the data read back
  assign issue = (state_q == ST_SCAN) && (iss_q < cnt_q);
  assign fits  = (CMP_W'(rd_size) >= CMP_W'(req_q));
  assign cand  = chk_valid_q && !used_q[chk_idx_q] && fits;
  assign take  = cand && (!found_q ||
                 ((policy_q == fpfa_pkg::POLICY_BEST)  && (rd_size < best_q)) ||
                 ((policy_q == fpfa_pkg::POLICY_WORST) && (rd_size > best_q)));
  assign scan_end = chk_valid_q &&
                    (chk_last_q || (cand && (policy_q == fpfa_pkg::POLICY_FIRST)));
  assign pick_wide = 32'(pick_q);

  // Sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    chk_valid_d = 1'b0;
    chk_last_d  = chk_last_q;
    chk_idx_d   = chk_idx_q;
    found_d     = found_q;
    pick_d      = pick_q;
    best_d      = best_q;
    req_d       = req_q;
    policy_d    = policy_q;
    out_valid_d = out_valid_q && out_stall_i;
    granted_d   = granted_q;
    gidx_d      = gidx_q;
    asked_d     = asked_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (func_i == fpfa_pkg::FUNC_LOAD) begin
            if (load_ok) begin
              used_d[ent_idx] = 1'b0;
            end
          end else begin
            req_d    = size_value_i;
            policy_d = cfg_policy_q;
            cnt_d    = eff_count;
            iss_d    = '0;
            found_d  = 1'b0;
            pick_d   = '0;
            if ((eff_count == '0) || (cfg_policy_q == fpfa_pkg::POLICY_REFUSE)) begin
              state_d = ST_DONE;
            end else begin
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        // Issue one read per cycle
        if (issue) begin
          chk_valid_d = 1'b1;
          chk_idx_d   = iss_q[IDX_W-1:0];
          chk_last_d  = (iss_q == (cnt_q - CNT_W'(1)));
          iss_d       = iss_q + CNT_W'(1);
        end
        // Track the current pick
        if (take) begin
          found_d = 1'b1;
          pick_d  = chk_idx_q;
          best_d  = rd_size;
        end
        if (scan_end) begin
          chk_valid_d = 1'b0;
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand the result over once the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          granted_d   = found_q;
          gidx_d      = found_q ? pick_wide[fpfa_pkg::ENTRY_W-1:0] : '0;
          asked_d     = req_q;
          if (found_q) begin
            used_d[pick_q] = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q  <= '0;
      cfg_policy_q <= fpfa_pkg::POLICY_FIRST;
      state_q      <= ST_IDLE;
      used_q       <= '0;
      chk_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          fpfa_pkg::REG_COUNT:  cfg_count_q  <= cfg_wdata_i[fpfa_pkg::COUNT_W-1:0];
          fpfa_pkg::REG_POLICY: cfg_policy_q <= cfg_wdata_i[fpfa_pkg::POLICY_W-1:0];
          default: ;
        endcase
      end
      state_q     <= state_d;
      used_q      <= used_d;
      chk_valid_q <= chk_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    iss_q      <= iss_d;
    chk_last_q <= chk_last_d;
    chk_idx_q  <= chk_idx_d;
    found_q    <= found_d;
    pick_q     <= pick_d;
    best_q     <= best_d;
    req_q      <= req_d;
    policy_q   <= policy_d;
    granted_q  <= granted_d;
    gidx_q     <= gidx_d;
    asked_q    <= asked_d;
  end

  assign out_valid_o     = out_valid_q;
  assign granted_o       = granted_q;
  assign granted_index_o = gidx_q;
  assign asked_size_o    = asked_q;

`ifndef SYNTHESIS
  // A read result is only checked during a scan
  a_chk_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_valid_q |-> (state_q == ST_SCAN))
    else $error("compare stage active outside scan");

  // The issue pointer never runs past the partition count
  a_iss_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (iss_q <= cnt_q))
    else $error("scan pointer beyond partition count");

  // A pick always lies inside the scanned range
  a_pick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && found_q) |-> (32'(pick_q) < 32'(cnt_q)))
    else $error("picked partition outside range");

  // A granted partition is marked used after the result is handed over
  a_mark_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && out_free && found_q) |=> used_q[$past(pick_q)])
    else $error("granted partition not marked used");

  // A refusal reports index zero
  a_refuse_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !granted_o) |-> (granted_index_o == '0))
    else $error("refusal with nonzero index");
`endif

endmodule
